### rtl/core/cbor_head_stream_parser_top_assert.svh
// ----------------------------------------------------------------------------
// CBOR head stream parser assertion macros
// Shorthand for the clocked, reset-qualified checks in the parser RTL.
// ----------------------------------------------------------------------------
`ifndef CBOR_HEAD_STREAM_PARSER_TOP_ASSERT_SVH
`define CBOR_HEAD_STREAM_PARSER_TOP_ASSERT_SVH

// Same-cycle implication, checked only while out of reset.
`define CHSP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("chsp same-cycle check failed");

// Next-cycle implication, checked only while out of reset.
`define CHSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("chsp next-cycle check failed");

`endif

### rtl/core/chsp_pkg.sv
// ----------------------------------------------------------------------------
// CBOR head stream parser package
// Types, codes and constants shared by the parser modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package chsp_pkg;

  // Parser phase, one-hot.
  typedef enum logic [3:0] {
    PH_HEAD = 4'b0001,
    PH_ARG  = 4'b0010,
    PH_PAY  = 4'b0100,
    PH_ERR  = 4'b1000
  } phase_t;

  // Event kinds reported with every item.
  localparam logic [2:0] EV_ARG  = 3'd0;
  localparam logic [2:0] EV_HEAD = 3'd1;
  localparam logic [2:0] EV_PAY  = 3'd2;
  localparam logic [2:0] EV_ERR  = 3'd3;
  localparam logic [2:0] EV_IGN  = 3'd4;

  // Error codes.
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_MAJOR     = 2'd1;
  localparam logic [1:0] ERR_RESERVED  = 2'd2;
  localparam logic [1:0] ERR_TRUNCATED = 2'd3;

  // Major types that carry a payload.
  localparam logic [2:0] MAJ_BYTES = 3'd2;
  localparam logic [2:0] MAJ_TEXT  = 3'd3;

  // Additional info decoding.
  localparam logic [7:0] INFO_MASK        = 8'h1F;
  localparam logic [4:0] INFO_ONE_BYTE    = 5'd24;
  localparam logic [4:0] INFO_TWO_BYTES   = 5'd25;
  localparam logic [4:0] INFO_FOUR_BYTES  = 5'd26;
  localparam logic [4:0] INFO_EIGHT_BYTES = 5'd27;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [2:0] expected_major;
    logic       buffer_end;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [2:0]  major_type;
    logic [63:0] head_value;
    logic [7:0]  payload_byte;
    logic        payload_last;
    logic [1:0]  error_code;
  } result_t;

  typedef struct packed {
    phase_t      phase;
    logic [3:0]  args_left;
    logic [63:0] acc;
    logic [2:0]  major;
    logic [63:0] pay_left;
  } state_t;

  localparam state_t STATE_CLEAR = '{
    phase:     PH_HEAD,
    args_left: 4'd0,
    acc:       64'd0,
    major:     3'd0,
    pay_left:  64'd0
  };

endpackage

### rtl/core/chsp_in_if.sv
// ----------------------------------------------------------------------------
// CBOR head stream parser input channel
// Valid/ready channel that carries one encoded byte per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface chsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [2:0] expected_major;
  logic       buffer_end;

  modport source (
    output valid, data_byte, expected_major, buffer_end,
    input  ready
  );

  modport sink (
    input  valid, data_byte, expected_major, buffer_end,
    output ready
  );
endinterface

### rtl/core/chsp_out_if.sv
// ----------------------------------------------------------------------------
// CBOR head stream parser result channel
// Valid/ready channel that carries one parse event per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface chsp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_kind;
  logic [2:0]  major_type;
  logic [63:0] head_value;
  logic [7:0]  payload_byte;
  logic        payload_last;
  logic [1:0]  error_code;

  modport source (
    output valid, event_kind, major_type, head_value, payload_byte,
           payload_last, error_code,
    input  ready
  );

  modport sink (
    input  valid, event_kind, major_type, head_value, payload_byte,
           payload_last, error_code,
    output ready
  );
endinterface

### rtl/core/chsp_step.sv
// ----------------------------------------------------------------------------
// CBOR head stream parser step logic
// Combinational decode of one byte against the parser state: gives the
// event for the byte and the parser state after it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module chsp_step (
  input  chsp_pkg::state_t   state_i,
  input  chsp_pkg::in_item_t item_i,
  output chsp_pkg::state_t   state_o,
  output chsp_pkg::result_t  res_o
);
  import chsp_pkg::*;

  logic [4:0]  info;
  logic [63:0] acc_shift;
  logic [3:0]  args_dec;
  logic [63:0] pay_dec;
  logic        pay_last;
  logic        is_string;

  assign info      = 5'(item_i.data_byte & INFO_MASK);
  assign acc_shift = {state_i.acc[55:0], item_i.data_byte};
  assign args_dec  = (state_i.args_left != 4'd0) ? state_i.args_left - 4'd1 : 4'd0;
  assign pay_dec   = (state_i.pay_left != 64'd0) ? state_i.pay_left - 64'd1 : 64'd0;
  assign pay_last  = (pay_dec == 64'd0);

  always_comb begin
    logic        fin;
    logic [63:0] fin_v;
    logic        err_now;
    logic [1:0]  err_code;
    logic [2:0]  maj_cur;

    fin      = 1'b0;
    fin_v    = 64'd0;
    err_now  = 1'b0;
    err_code = ERR_NONE;
    maj_cur  = state_i.major;
    state_o  = state_i;
    res_o    = '0;

    // Per-phase handling of the byte.
    case (state_i.phase)
      PH_HEAD: begin
        maj_cur       = item_i.data_byte[7:5];
        state_o.major = maj_cur;
        if (maj_cur != item_i.expected_major) begin
          err_now  = 1'b1;
          err_code = ERR_MAJOR;
        end else if (info < INFO_ONE_BYTE) begin
          fin   = 1'b1;
          fin_v = {59'd0, info};
        end else if (info inside {[INFO_ONE_BYTE:INFO_EIGHT_BYTES]}) begin
          if (item_i.buffer_end) begin
            err_now  = 1'b1;
            err_code = ERR_TRUNCATED;
          end else begin
            case (info)
              INFO_ONE_BYTE:   state_o.args_left = 4'd1;
              INFO_TWO_BYTES:  state_o.args_left = 4'd2;
              INFO_FOUR_BYTES: state_o.args_left = 4'd4;
              default:         state_o.args_left = 4'd8;
            endcase
            state_o.acc      = 64'd0;
            state_o.phase    = PH_ARG;
            res_o.event_kind = EV_ARG;
          end
        end else begin
          err_now  = 1'b1;
          err_code = ERR_RESERVED;
        end
      end
      PH_ARG: begin
        state_o.acc       = acc_shift;
        state_o.args_left = args_dec;
        if (args_dec == 4'd0) begin
          fin   = 1'b1;
          fin_v = acc_shift;
        end else if (item_i.buffer_end) begin
          err_now  = 1'b1;
          err_code = ERR_TRUNCATED;
        end else begin
          res_o.event_kind = EV_ARG;
          res_o.head_value = acc_shift;
        end
      end
      PH_PAY: begin
        state_o.pay_left = pay_dec;
        if (!pay_last && item_i.buffer_end) begin
          err_now  = 1'b1;
          err_code = ERR_TRUNCATED;
        end else begin
          if (pay_last) begin
            state_o.phase = PH_HEAD;
          end
          res_o.event_kind   = EV_PAY;
          res_o.head_value   = pay_dec;
          res_o.payload_byte = item_i.data_byte;
          res_o.payload_last = pay_last;
        end
      end
      default: begin
        // Sticky error: ignore bytes until the buffer ends.
        res_o.event_kind = EV_IGN;
        if (item_i.buffer_end) begin
          state_o = STATE_CLEAR;
        end
      end
    endcase

    // A finished head opens a string payload, awaits a head, or errors.
    is_string = (maj_cur == MAJ_BYTES) || (maj_cur == MAJ_TEXT);
    if (fin) begin
      if (is_string && fin_v != 64'd0 && item_i.buffer_end) begin
        err_now  = 1'b1;
        err_code = ERR_TRUNCATED;
      end else begin
        if (is_string && fin_v != 64'd0) begin
          state_o.phase    = PH_PAY;
          state_o.pay_left = fin_v;
        end else begin
          state_o.phase = PH_HEAD;
        end
        state_o.args_left = 4'd0;
        state_o.acc       = fin_v;
        res_o.event_kind  = EV_HEAD;
        res_o.head_value  = fin_v;
      end
    end

    // Error reporting: rearm at buffer end, otherwise go sticky.
    if (err_now) begin
      res_o            = '0;
      res_o.event_kind = EV_ERR;
      res_o.error_code = err_code;
      if (item_i.buffer_end) begin
        state_o = STATE_CLEAR;
      end else begin
        state_o.phase = PH_ERR;
      end
    end

    res_o.major_type = maj_cur;
  end

endmodule

### rtl/core/cbor_head_stream_parser_top.sv
// ----------------------------------------------------------------------------
// CBOR head stream parser
// Parses a CBOR byte stream one byte per item and reports one event per byte.
//
//   Channel  Dir  Handshake     Item contents
//   in_ch    in   valid/ready   data_byte, expected_major, buffer_end
//   out_ch   out  valid/ready   event_kind, major_type, head_value,
//                               payload_byte, payload_last, error_code
//
// One item per clock sustained while out_ch takes results; items pass the input
// register, then the result register. The parser state advances once per item
// in a single pass of the step logic, which sets the rate. Reset is synchronous
// and needs no clearing pass. While out_ch stalls, the result is held and the
// input register still takes one more item before in_ch.ready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "cbor_head_stream_parser_top_assert.svh"

module cbor_head_stream_parser_top (
  input  logic       clk,
  input  logic       rst_n,
  chsp_in_if.sink    in_ch,
  chsp_out_if.source out_ch
);
  import chsp_pkg::*;

  logic     s1_valid_r;
  in_item_t s1_item_r;
  logic     s1_adv;
  logic     out_valid_r;
  result_t  out_res_r;
  result_t  step_res;
  state_t   state_r;
  state_t   state_nxt;

  // The input stage moves on when the result register is free or drains.
  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_item_r.data_byte      <= in_ch.data_byte;
      s1_item_r.expected_major <= in_ch.expected_major;
      s1_item_r.buffer_end     <= in_ch.buffer_end;
    end
  end

  // Byte decode against the current parser state.
  chsp_step u_step (
    .state_i (state_r),
    .item_i  (s1_item_r),
    .state_o (state_nxt),
    .res_o   (step_res)
  );

  // Parser state advances once per item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_CLEAR;
    end else if (s1_adv) begin
      state_r <= state_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res_r <= step_res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.event_kind   = out_res_r.event_kind;
  assign out_ch.major_type   = out_res_r.major_type;
  assign out_ch.head_value   = out_res_r.head_value;
  assign out_ch.payload_byte = out_res_r.payload_byte;
  assign out_ch.payload_last = out_res_r.payload_last;
  assign out_ch.error_code   = out_res_r.error_code;

  // Checks on the parser bookkeeping.
  `CHSP_ASSERT_IMPLY(a_code_only_on_error, clk, rst_n, out_valid_r && out_res_r.event_kind != EV_ERR, out_res_r.error_code == ERR_NONE)
  `CHSP_ASSERT_IMPLY(a_arg_bytes_owed, clk, rst_n, state_r.phase == PH_ARG, state_r.args_left != 4'd0)
  `CHSP_ASSERT_IMPLY(a_payload_owed, clk, rst_n, state_r.phase == PH_PAY, state_r.pay_left != 64'd0)
  `CHSP_ASSERT_IMPLY(a_ready_when_empty, clk, rst_n, !out_valid_r, in_ch.ready)

endmodule

### bench/cbor_head_stream_parser_top_tb.sv
// ----------------------------------------------------------------------------
// CBOR head stream parser testbench
// Sends encoded buffers one byte per item and predicts the parse event for
// every accepted byte. Results are checked field by field, in order, against
// the predicted events. Directed buffers cover the value extremes, empty and
// short strings, and every error path. A long result stall fills the parser.
// Random well-formed, cut-short and noisy buffers follow.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cbor_head_stream_parser_top_tb;
  import chsp_pkg::*;

  // Major types and info codes used by the directed buffers.
  localparam logic [2:0] MAJ_UINT   = 3'd0;
  localparam logic [2:0] MAJ_NEGINT = 3'd1;
  localparam logic [2:0] MAJ_ARRAY  = 3'd4;
  localparam logic [2:0] MAJ_SIMPLE = 3'd7;
  localparam logic [4:0] INFO_RESERVED_LOW = 5'd28;
  localparam logic [4:0] INFO_INDEFINITE   = 5'd31;

  localparam int ITEM_TARGET  = 1150;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_LIMIT  = 5000;
  localparam int REPORT_LIMIT = 10;
  localparam int TIMEOUT_NS   = 5_000_000;

  logic clk = 1'b0;
  logic rst_n;

  chsp_in_if  in_ch ();
  chsp_out_if out_ch ();

  cbor_head_stream_parser_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Free-running 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted parser state.
  phase_t      ps_phase;
  logic [3:0]  ps_args_left;
  logic [63:0] ps_acc;
  logic [2:0]  ps_major;
  logic [63:0] ps_pay_left;

  result_t  expected_events[$];
  in_item_t frame_q[$];

  int  bytes_sent    = 0;
  int  buffers_sent  = 0;
  int  events_checked = 0;
  int  error_count   = 0;
  int  kind_seen[0:4] = '{default: 0};
  bit  idle_on       = 1'b1;
  int  hold_request  = 0;
  bit  hold_active   = 1'b0;
  int  holds_done    = 0;

  // ------------------------------------------------------------------------
  // Event prediction
  // ------------------------------------------------------------------------

  function automatic void clear_parse_state();
    ps_phase     = PH_HEAD;
    ps_args_left = '0;
    ps_acc       = '0;
    ps_major     = '0;
    ps_pay_left  = '0;
  endfunction

  function automatic result_t make_event(logic [2:0] kind, logic [63:0] value,
                                         logic [7:0] pbyte, logic plast,
                                         logic [1:0] code);
    result_t r;
    r.event_kind   = kind;
    r.major_type   = ps_major;
    r.head_value   = value;
    r.payload_byte = pbyte;
    r.payload_last = plast;
    r.error_code   = code;
    return r;
  endfunction

  // An error at the end of a buffer rearms at once; otherwise it sticks.
  function automatic result_t raise_error(logic [1:0] code, logic at_end);
    result_t r;
    r = make_event(EV_ERR, '0, '0, 1'b0, code);
    if (at_end) begin
      clear_parse_state();
    end else begin
      ps_phase = PH_ERR;
    end
    return r;
  endfunction

  // A finished head of a nonempty string owes its payload bytes.
  function automatic result_t close_head(logic [63:0] v, logic at_end);
    if ((ps_major == MAJ_BYTES || ps_major == MAJ_TEXT) && v != '0) begin
      if (at_end) return raise_error(ERR_TRUNCATED, 1'b1);
      ps_phase    = PH_PAY;
      ps_pay_left = v;
    end else begin
      ps_phase = PH_HEAD;
    end
    ps_args_left = '0;
    ps_acc       = v;
    return make_event(EV_HEAD, v, '0, 1'b0, ERR_NONE);
  endfunction

  function automatic result_t parse_byte(in_item_t it);
    result_t    r;
    logic [4:0] info;
    logic       last;
    info = it.data_byte[4:0];
    case (ps_phase)
      PH_HEAD: begin
        ps_major = it.data_byte[7:5];
        if (ps_major != it.expected_major) return raise_error(ERR_MAJOR, it.buffer_end);
        if (info < INFO_ONE_BYTE) return close_head({59'd0, info}, it.buffer_end);
        if (info > INFO_EIGHT_BYTES) return raise_error(ERR_RESERVED, it.buffer_end);
        if (it.buffer_end) return raise_error(ERR_TRUNCATED, 1'b1);
        case (info)
          INFO_ONE_BYTE:   ps_args_left = 4'd1;
          INFO_TWO_BYTES:  ps_args_left = 4'd2;
          INFO_FOUR_BYTES: ps_args_left = 4'd4;
          default:         ps_args_left = 4'd8;
        endcase
        ps_acc   = '0;
        ps_phase = PH_ARG;
        return make_event(EV_ARG, '0, '0, 1'b0, ERR_NONE);
      end
      PH_ARG: begin
        ps_acc = {ps_acc[55:0], it.data_byte};
        if (ps_args_left != 4'd0) ps_args_left = ps_args_left - 4'd1;
        if (ps_args_left == 4'd0) return close_head(ps_acc, it.buffer_end);
        if (it.buffer_end) return raise_error(ERR_TRUNCATED, 1'b1);
        return make_event(EV_ARG, ps_acc, '0, 1'b0, ERR_NONE);
      end
      PH_PAY: begin
        if (ps_pay_left != '0) ps_pay_left = ps_pay_left - 64'd1;
        last = (ps_pay_left == '0);
        if (!last && it.buffer_end) return raise_error(ERR_TRUNCATED, 1'b1);
        if (last) ps_phase = PH_HEAD;
        return make_event(EV_PAY, ps_pay_left, it.data_byte, last, ERR_NONE);
      end
      default: begin
        r = make_event(EV_IGN, '0, '0, 1'b0, ERR_NONE);
        if (it.buffer_end) clear_parse_state();
        return r;
      end
    endcase
  endfunction

  // ------------------------------------------------------------------------
  // Buffer building
  // ------------------------------------------------------------------------

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [2:0] any_major();
    logic [2:0] m;
    m = 3'($urandom_range(0, 7));
    return m;
  endfunction

  function automatic int any_width();
    case ($urandom_range(0, 4))
      0:       return 0;
      1:       return 1;
      2:       return 2;
      3:       return 4;
      default: return 8;
    endcase
  endfunction

  // Random argument that fits the given width, with the extremes favored.
  function automatic logic [63:0] value_for(int nbytes);
    logic [63:0] v;
    int          r;
    r = $urandom_range(0, 9);
    v = {$urandom, $urandom};
    if (r == 0) v = '0;
    if (r == 1) v = '1;
    if (nbytes == 0) begin
      v = (r == 1) ? 64'd23 : (r == 0) ? 64'd0 : 64'($urandom_range(0, 23));
    end else if (nbytes < 8) begin
      v = v & ((64'd1 << (8 * nbytes)) - 64'd1);
    end
    return v;
  endfunction

  function automatic void push_byte(logic [7:0] b, logic [2:0] em);
    in_item_t it;
    it.data_byte      = b;
    it.expected_major = em;
    it.buffer_end     = 1'b0;
    frame_q.insert(frame_q.size(), it);
  endfunction

  // Head with an immediate value (width 0) or 1, 2, 4 or 8 argument bytes.
  function automatic void push_head(logic [2:0] mt, int nbytes, logic [63:0] val);
    logic [4:0] info;
    case (nbytes)
      1:       info = INFO_ONE_BYTE;
      2:       info = INFO_TWO_BYTES;
      4:       info = INFO_FOUR_BYTES;
      8:       info = INFO_EIGHT_BYTES;
      default: info = val[4:0];
    endcase
    push_byte({mt, info}, mt);
    for (int i = nbytes - 1; i >= 0; i--) push_byte(val[8*i +: 8], any_major());
  endfunction

  // One well-formed data item; strings are kept short.
  function automatic void push_data_item();
    logic [2:0] mt;
    int         nbytes;
    int         len;
    mt = any_major();
    if (mt == MAJ_BYTES || mt == MAJ_TEXT) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
      nbytes = any_width();
      if (len > 23 && nbytes == 0) nbytes = 1;
      push_head(mt, nbytes, 64'(len));
      repeat (len) push_byte(8'($urandom), any_major());
    end else begin
      nbytes = any_width();
      push_head(mt, nbytes, value_for(nbytes));
    end
  endfunction

  // ------------------------------------------------------------------------
  // Sending
  // ------------------------------------------------------------------------

  // Offer one byte after a random gap and predict its event on acceptance.
  task automatic send_byte(in_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.data_byte      <= it.data_byte;
    in_ch.expected_major <= it.expected_major;
    in_ch.buffer_end     <= it.buffer_end;
    do @(posedge clk); while (!in_ch.ready);
    expected_events.insert(expected_events.size(), parse_byte(it));
    bytes_sent++;
  endtask

  // Mark the last queued byte as the end of the buffer and send them all.
  task automatic send_frame();
    in_item_t it;
    if (frame_q.size() == 0) return;
    it = frame_q.pop_back();
    it.buffer_end = 1'b1;
    frame_q.insert(frame_q.size(), it);
    while (frame_q.size() > 0) begin
      it = frame_q.pop_front();
      send_byte(it);
    end
    buffers_sent++;
  endtask

  task automatic send_random_frame();
    in_item_t it;
    int       pick;
    int       cut;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      // Well-formed buffer of a few data items.
      repeat ($urandom_range(1, 4)) push_data_item();
    end else if (pick < 72) begin
      // Well-formed items, cut at a random byte.
      repeat ($urandom_range(1, 3)) push_data_item();
      cut = $urandom_range(1, frame_q.size());
      while (frame_q.size() > cut) it = frame_q.pop_back();
    end else if (pick < 78) begin
      // String with a huge length, cut after a few payload bytes.
      cut = ($urandom_range(0, 1) == 0) ? 4 : 8;
      push_head($urandom_range(0, 1) ? MAJ_TEXT : MAJ_BYTES, cut,
                value_for(cut) | (64'd1 << 20));
      repeat ($urandom_range(0, 4)) push_byte(8'($urandom), any_major());
    end else if (pick < 88) begin
      // Bad head, then bytes that the parser must ignore.
      push_data_item();
      it = frame_q.pop_front();
      if ($urandom_range(0, 1) == 0) begin
        it.expected_major = it.data_byte[7:5] ^ 3'($urandom_range(1, 7));
      end else begin
        it.data_byte[4:0] = 5'($urandom_range(INFO_RESERVED_LOW, INFO_INDEFINITE));
      end
      frame_q.push_front(it);
      repeat ($urandom_range(0, 3)) push_byte(8'($urandom), any_major());
    end else begin
      // Raw noise.
      repeat ($urandom_range(1, 6)) push_byte(8'($urandom), any_major());
    end
    send_frame();
  endtask

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------

  // Immediate values at both extremes, and empty strings.
  task automatic test_immediate_heads();
    push_head(MAJ_UINT, 0, 64'd0);
    push_head(MAJ_NEGINT, 0, 64'd23);
    push_head(MAJ_SIMPLE, 0, 64'd23);
    send_frame();
    push_head(MAJ_BYTES, 0, 64'd0);
    push_head(MAJ_TEXT, 0, 64'd0);
    send_frame();
  endtask

  // Eight argument bytes carrying the largest value.
  task automatic test_long_argument();
    push_head(MAJ_UINT, 8, '1);
    send_frame();
  endtask

  // Short byte string whose final payload byte ends the buffer.
  task automatic test_string_payload();
    push_head(MAJ_BYTES, 0, 64'd2);
    push_byte(8'hFF, MAJ_SIMPLE);
    push_byte(8'h00, MAJ_UINT);
    send_frame();
  endtask

  task automatic test_error_paths();
    // Wrong major type, then an ignored byte that rearms the parser.
    push_byte({MAJ_TEXT, 5'd1}, MAJ_UINT);
    push_byte(8'hA5, MAJ_TEXT);
    send_frame();
    // Indefinite length at the end of a buffer.
    push_byte({MAJ_ARRAY, INFO_INDEFINITE}, MAJ_ARRAY);
    send_frame();
    // Reserved info, then an ignored byte.
    push_byte({MAJ_UINT, INFO_RESERVED_LOW}, MAJ_UINT);
    push_byte(8'h5A, MAJ_UINT);
    send_frame();
    // Buffer ends on a head that announces argument bytes.
    push_byte({MAJ_UINT, INFO_FOUR_BYTES}, MAJ_UINT);
    send_frame();
    // Buffer ends between argument bytes.
    push_head(MAJ_NEGINT, 2, 64'h1234);
    void'(frame_q.pop_back());
    send_frame();
    // Buffer ends on a string head that owes payload.
    push_head(MAJ_TEXT, 0, 64'd5);
    send_frame();
    // Buffer ends inside a payload.
    push_head(MAJ_BYTES, 0, 64'd3);
    push_byte(8'h81, MAJ_BYTES);
    send_frame();
  endtask

  // Long result stall while bytes keep coming, so the parser stops taking them.
  task automatic test_back_pressure();
    idle_on = 1'b0;
    hold_request = HOLD_CYCLES;
    wait (hold_active);
    while (frame_q.size() < 24) push_data_item();
    send_frame();
    idle_on = 1'b1;
  endtask

  // Back-to-back bytes with both sides always ready.
  task automatic test_streaming();
    int stop_at;
    idle_on = 1'b0;
    stop_at = bytes_sent + 150;
    while (bytes_sent < stop_at) send_random_frame();
    idle_on = 1'b1;
  endtask

  task automatic test_random_buffers();
    while (bytes_sent < ITEM_TARGET) send_random_frame();
  endtask

  // ------------------------------------------------------------------------
  // Result side
  // ------------------------------------------------------------------------

  // Ready with random stalls, plus a long hold when a test asks for one.
  initial begin : drain_results
    int gap;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_request > 0) begin
        out_ch.ready <= 1'b0;
        hold_active = 1'b1;
        repeat (hold_request) @(posedge clk);
        hold_request = 0;
        hold_active  = 1'b0;
        holds_done++;
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          out_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      error_count++;
      if (error_count <= REPORT_LIMIT) begin
        $display("Mismatch in %s of event %0d: expected %0h, got %0h",
                 name, events_checked, want, got);
      end
    end
  endtask

  // Compare each accepted event with the oldest prediction.
  always @(posedge clk) begin : check_events
    result_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (out_ch.event_kind <= EV_IGN) kind_seen[out_ch.event_kind]++;
      if (expected_events.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_LIMIT) begin
          $display("Event with nothing predicted: kind %0d", out_ch.event_kind);
        end
      end else begin
        want = expected_events.pop_front();
        check_field("event_kind", 64'(want.event_kind), 64'(out_ch.event_kind));
        check_field("major_type", 64'(want.major_type), 64'(out_ch.major_type));
        check_field("head_value", want.head_value, out_ch.head_value);
        check_field("payload_byte", 64'(want.payload_byte), 64'(out_ch.payload_byte));
        check_field("payload_last", 64'(want.payload_last), 64'(out_ch.payload_last));
        check_field("error_code", 64'(want.error_code), 64'(out_ch.error_code));
        events_checked++;
      end
    end
  end

  // ------------------------------------------------------------------------
  // Sequence
  // ------------------------------------------------------------------------

  initial begin : run_tests
    int waited;
    rst_n                <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.data_byte      <= '0;
    in_ch.expected_major <= '0;
    in_ch.buffer_end     <= 1'b0;
    clear_parse_state();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_immediate_heads();
    test_long_argument();
    test_string_payload();
    test_error_paths();
    test_back_pressure();
    test_streaming();
    test_random_buffers();

    // Let the last events drain.
    in_ch.valid <= 1'b0;
    waited = 0;
    while (expected_events.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (expected_events.size() != 0) begin
      error_count += expected_events.size();
      $display("%0d predicted events never arrived", expected_events.size());
    end

    $display("Sent %0d bytes in %0d buffers, checked %0d events, %0d long result stall(s).",
             bytes_sent, buffers_sent, events_checked, holds_done);
    $display("Events by kind: %0d argument, %0d head, %0d payload, %0d error, %0d ignored.",
             kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4]);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Hard stop if the handshakes hang.
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Timeout with %0d events still predicted", expected_events.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
